// ===== rtl/fifo_fed_bit_serializer_assert.svh =====
`ifndef FIFO_FED_BIT_SERIALIZER_ASSERT_SVH
`define FIFO_FED_BIT_SERIALIZER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FBS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/fbs_pkg.sv =====
package fbs_pkg;

   // ring store
   localparam int FIFO_DEPTH = 64;
   localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

   // field widths
   localparam int BYTE_W    = 8;
   localparam int REMAIN_W  = 4;
   localparam int COUNT_W   = 6;
   localparam int BIT_POS_W = 4;

   // serial frame
   localparam int BITS_PER_BYTE = 8;
   localparam int BIT_SEL_W     = $clog2(BITS_PER_BYTE);

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_PUSH = 2'd1,
      OP_HOLD = 2'd2
   } op_type;

   typedef struct packed {
      logic                cmd;
      logic [BYTE_W-1:0]   data_byte;
      logic [REMAIN_W-1:0] shift_remaining;
   } req_type;

   typedef struct packed {
      logic               line_level;
      logic               start_edge;
      logic               push_refused;
      logic [COUNT_W-1:0] fifo_count;
      logic               busy_res;
   } rsp_type;

   typedef struct packed {
      op_type              op;
      logic [BYTE_W-1:0]   data_byte;
      logic [REMAIN_W-1:0] shift_remaining;
   } q_entry_type;

   typedef struct packed {
      logic valid;
      logic full;
   } q_status_type;

endpackage

// ===== rtl/fbs_front.sv =====
module fbs_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  fbs_pkg::req_type     req,
   input  logic                 csr_write_en,
   input  logic                 csr_write_data,
   input  fbs_pkg::q_status_type q_status,
   output logic                 q_push,
   output fbs_pkg::q_entry_type q_entry
);

   logic port_attached_ff;
   logic port_attached_in;

   always_comb begin
      port_attached_in = port_attached_ff;
      if (csr_write_en) begin
         port_attached_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         port_attached_ff <= 1'b1;
      end else begin
         port_attached_ff <= port_attached_in;
      end
   end

   assign req_ready = !q_status.full;
   assign q_push    = req_valid && !q_status.full;

   // a tick on a detached port is a no-op for the back end
   always_comb begin
      q_entry.data_byte       = req.data_byte;
      q_entry.shift_remaining = req.shift_remaining;
      if (req.cmd) begin
         q_entry.op = fbs_pkg::OP_PUSH;
      end else if (port_attached_ff) begin
         q_entry.op = fbs_pkg::OP_TICK;
      end else begin
         q_entry.op = fbs_pkg::OP_HOLD;
      end
   end

endmodule

// ===== rtl/fbs_queue.sv =====
module fbs_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  fbs_pkg::q_entry_type   push_entry,
   input  logic                   pop,
   output fbs_pkg::q_status_type  status,
   output fbs_pkg::q_entry_type   head
);

   localparam logic [fbs_pkg::QPTR_W-1:0] LAST_SLOT =
      fbs_pkg::QPTR_W'(fbs_pkg::QUEUE_DEPTH - 1);
   localparam logic [fbs_pkg::QCNT_W-1:0] FULL_CNT =
      fbs_pkg::QCNT_W'(fbs_pkg::QUEUE_DEPTH);

   fbs_pkg::q_entry_type          slot_ff [fbs_pkg::QUEUE_DEPTH];
   logic [fbs_pkg::QPTR_W-1:0]    wr_ptr_ff;
   logic [fbs_pkg::QPTR_W-1:0]    wr_ptr_in;
   logic [fbs_pkg::QPTR_W-1:0]    rd_ptr_ff;
   logic [fbs_pkg::QPTR_W-1:0]    rd_ptr_in;
   logic [fbs_pkg::QCNT_W-1:0]    cnt_ff;
   logic [fbs_pkg::QCNT_W-1:0]    cnt_in;

   assign status.valid = (cnt_ff != '0);
   assign status.full  = (cnt_ff == FULL_CNT);
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/fbs_back.sv =====
module fbs_back (
   input  logic                  clock,
   input  logic                  reset,
   input  fbs_pkg::q_status_type q_status,
   input  fbs_pkg::q_entry_type  q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output fbs_pkg::rsp_type      rsp
);

   localparam logic [fbs_pkg::PTR_W-1:0] LAST_IDX =
      fbs_pkg::PTR_W'(fbs_pkg::FIFO_DEPTH - 1);
   localparam logic [fbs_pkg::PTR_W-1:0] FULL_FILL =
      fbs_pkg::PTR_W'(fbs_pkg::FIFO_DEPTH - 1);
   localparam logic [fbs_pkg::BIT_POS_W-1:0] FRAME_BITS =
      fbs_pkg::BIT_POS_W'(fbs_pkg::BITS_PER_BYTE);

   logic [fbs_pkg::BYTE_W-1:0]    store_mem [fbs_pkg::FIFO_DEPTH];

   logic [fbs_pkg::PTR_W-1:0]     wr_ptr_ff,  wr_ptr_in;
   logic [fbs_pkg::PTR_W-1:0]     rd_ptr_ff,  rd_ptr_in;
   logic [fbs_pkg::PTR_W-1:0]     fill_ff,    fill_in;
   logic [fbs_pkg::BYTE_W-1:0]    head_ff;
   logic                          shifting_ff, shifting_in;
   logic [fbs_pkg::BYTE_W-1:0]    held_ff,    held_in;
   logic [fbs_pkg::BIT_POS_W-1:0] bit_pos_ff, bit_pos_in;
   logic [fbs_pkg::REMAIN_W-1:0]  last_rem_ff, last_rem_in;
   logic                          line_ff,    line_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   fbs_pkg::rsp_type              rsp_ff,     rsp_in;

   logic                          go;
   logic                          store_we;
   logic                          head_bypass;
   logic                          edge_flag;
   logic                          refused;

   // one op per cycle whenever the output register is free or draining
   assign go    = q_status.valid && (!rsp_valid_ff || rsp_ready);
   assign q_pop = go;

   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      fill_in     = fill_ff;
      shifting_in = shifting_ff;
      held_in     = held_ff;
      bit_pos_in  = bit_pos_ff;
      last_rem_in = last_rem_ff;
      line_in     = line_ff;
      store_we    = 1'b0;
      head_bypass = 1'b0;
      edge_flag   = 1'b0;
      refused     = 1'b0;

      if (go) begin
         unique case (q_head.op)
            fbs_pkg::OP_PUSH: begin
               if (fill_ff == FULL_FILL) begin
                  refused = 1'b1;
               end else begin
                  store_we    = 1'b1;
                  head_bypass = (fill_ff == '0);
                  wr_ptr_in   = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
                  fill_in     = fill_ff + 1'b1;
               end
            end
            fbs_pkg::OP_TICK: begin
               if (!shifting_ff) begin
                  if (fill_ff != '0) begin
                     held_in     = head_ff;
                     rd_ptr_in   = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
                     fill_in     = fill_ff - 1'b1;
                     bit_pos_in  = '0;
                     edge_flag   = 1'b1;
                     line_in     = head_ff[0];
                     last_rem_in = q_head.shift_remaining;
                     shifting_in = 1'b1;
                  end
               end else if (q_head.shift_remaining < last_rem_ff) begin
                  bit_pos_in  = bit_pos_ff + 1'b1;
                  last_rem_in = q_head.shift_remaining;
                  if (bit_pos_in < FRAME_BITS) begin
                     line_in = held_ff[bit_pos_in[fbs_pkg::BIT_SEL_W-1:0]];
                  end else begin
                     line_in     = 1'b1;
                     shifting_in = 1'b0;
                  end
               end
            end
            default: begin
               // detached tick: state holds
            end
         endcase
      end

      rsp_in.line_level   = line_in;
      rsp_in.start_edge   = edge_flag;
      rsp_in.push_refused = refused;
      rsp_in.fifo_count   = fbs_pkg::COUNT_W'(fill_in);
      rsp_in.busy_res     = shifting_in;

      rsp_valid_in = rsp_valid_ff;
      if (go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         fill_ff      <= '0;
         shifting_ff  <= 1'b0;
         held_ff      <= '0;
         bit_pos_ff   <= '0;
         last_rem_ff  <= '0;
         line_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         fill_ff      <= fill_in;
         shifting_ff  <= shifting_in;
         held_ff      <= held_in;
         bit_pos_ff   <= bit_pos_in;
         last_rem_ff  <= last_rem_in;
         line_ff      <= line_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rsp_ff <= rsp_in;
      end
   end

   // ring store; head_ff tracks the entry at the read pointer, with a
   // bypass for a push into an empty store
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[wr_ptr_ff] <= q_head.data_byte;
      end
      if (head_bypass) begin
         head_ff <= q_head.data_byte;
      end else begin
         head_ff <= store_mem[rd_ptr_in];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== rtl/fifo_fed_bit_serializer.sv =====
// A request beat is registered in the queue and then in the back end's output register before
// its result beat is presented; a stalling result side holds it in the queue.
// Throughput: one request beat per cycle, sustained while the result side is not stalling.
// Reset: synchronous, active high; empties the byte ring, idles the line high
// and attaches the port. The ring store itself is not cleared.
`include "fifo_fed_bit_serializer_assert.svh"

module fifo_fed_bit_serializer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fbs_pkg::req_type  req,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fbs_pkg::rsp_type  rsp,
   input  logic              csr_write_en,
   input  logic              csr_write_data
);

   // Front: holds port_attached and tags each beat as push, tick or
   // detached tick (no-op).
   // Queue: two entries, so the front can take beats while the back
   // waits on a stalled result register, until the queue fills.
   // Back: ring FIFO, serializer state and the output register, one op a cycle unless stalled.

   fbs_pkg::q_status_type q_status;
   fbs_pkg::q_entry_type  q_entry;
   fbs_pkg::q_entry_type  q_head;
   logic                  q_push;
   logic                  q_pop;

   fbs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req            (req),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .q_status       (q_status),
      .q_push         (q_push),
      .q_entry        (q_entry)
   );

   fbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .status     (q_status),
      .head       (q_head)
   );

   fbs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   // a start beat always leaves the serializer busy
   `FBS_ASSERT_NOW(a_start_busy, clock, reset, rsp_valid && rsp.start_edge, rsp.busy_res, "start without busy")
   // an idle serializer keeps the line high
   `FBS_ASSERT_NOW(a_idle_high, clock, reset, rsp_valid && !rsp.busy_res, rsp.line_level, "idle line low")
   // a refused push never starts a byte
   `FBS_ASSERT_NOW(a_refuse_no_start, clock, reset, rsp_valid && rsp.push_refused, !rsp.start_edge, "refused push started a byte")
   // a queued beat with a free result register yields a result next cycle
   `FBS_ASSERT_NEXT(a_beat_flows, clock, reset, q_status.valid && (!rsp_valid || rsp_ready), rsp_valid, "beat stuck in queue")

endmodule
